FILE: sv/pwsd_pkg.sv
// Package with the types, constants and sigmoid table of the PID unit with adaptive deadband.
`timescale 1ns / 1ps
package pwsd_pkg;

  localparam int FRAC_BITS   = 16;
  localparam int SIG_DEPTH   = 256;
  localparam int SIG_IDX_W   = $clog2(SIG_DEPTH);
  localparam int SIG_W       = FRAC_BITS + 1;
  localparam int X_SHIFT     = FRAC_BITS + 3;
  localparam int X_W         = X_SHIFT + 1;
  localparam int SIG_FR_W    = X_SHIFT - SIG_IDX_W;
  localparam int DIVN_W      = 52;
  localparam int DIVD_W      = 20;
  localparam int DIV_RADIX   = 2;

  localparam logic [X_W-1:0]        X_LIMIT   = X_W'(8) << FRAC_BITS;
  localparam logic [SIG_W-1:0]      SIG_ONE   = SIG_W'(1) << FRAC_BITS;
  localparam logic signed [34:0]    INT_LIMIT = 35'(100) << FRAC_BITS;
  localparam logic signed [63:0]    OUT_LIMIT = 64'(50) << FRAC_BITS;
  localparam logic [60:0]           MAG_CAP   = 61'(1) << 60;
  localparam logic [DIVD_W-1:0]     US_PER_S  = DIVD_W'(1000000);

  localparam logic signed [31:0] GAIN_P_RST = 32'sd32768;
  localparam logic signed [31:0] GAIN_I_RST = 32'sd6554;
  localparam logic signed [31:0] GAIN_D_RST = 32'sd3277;

  typedef enum logic [2:0] {
    CFG_GAIN_P, CFG_GAIN_I, CFG_GAIN_D, CFG_DZ_THRESHOLD,
    CFG_COEF_MIN, CFG_COEF_MAX, CFG_SIG_SLOPE, CFG_SIG_CENTER
  } cfg_idx_e;

  typedef enum logic [4:0] {
    ST_IDLE, ST_CHECK, ST_RATIO, ST_XMUL, ST_XCAP, ST_TAB, ST_INTERP_MUL, ST_SIG,
    ST_CMUL, ST_COEF, ST_LMUL, ST_LIMIT, ST_DTMUL, ST_DTDIV, ST_DTWAIT, ST_DRMUL,
    ST_DRDIV, ST_DRWAIT, ST_PMUL, ST_PACC, ST_GIMUL, ST_GIACC, ST_GDMLO, ST_GDMHI,
    ST_GDACC, ST_SAT, ST_FIN
  } state_e;

  typedef struct packed {
    logic               mode;
    logic signed [31:0] error_in;
    logic [19:0]        step_time_us;
    logic [12:0]        target_width;
    logic [13:0]        frame_size;
  } pwsd_in_t;

  typedef struct packed {
    logic signed [22:0] drive_out;
    logic               step_rejected;
  } pwsd_out_t;

  typedef logic [SIG_W-1:0] sig_tab_t [SIG_DEPTH+1];

  function automatic logic [SIG_W-1:0] sig_entry(int unsigned k);
    logic [63:0] y, y2, y3, y4, e, den, num, rem, quo;
    y  = (64'(k) << 27) / SIG_DEPTH;
    y2 = (y * y) >> 30;
    y3 = (y2 * y) >> 30;
    y4 = (y3 * y) >> 30;
    e  = ((64'(1) << 30) + y2 / 2 + y4 / 24) - (y + y3 / 6);
    for (int i = 0; i < 6; i++) begin
      e = (e * e) >> 30;
    end
    den = (64'(1) << 30) + e;
    num = 64'(1) << (30 + FRAC_BITS);
    rem = '0;
    quo = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[62:0], num[i]};
      quo = {quo[62:0], 1'b0};
      if (rem >= den) begin
        rem = rem - den;
        quo[0] = 1'b1;
      end
    end
    return quo[SIG_W-1:0];
  endfunction

  function automatic sig_tab_t build_sig_tab();
    sig_tab_t t;
    for (int k = 0; k <= SIG_DEPTH; k++) begin
      t[k] = sig_entry(k);
    end
    return t;
  endfunction

  localparam sig_tab_t SIG_TAB = build_sig_tab();

  function automatic logic [63:0] mag64(logic signed [63:0] v);
    return v[63] ? 64'(-v) : 64'(v);
  endfunction

  // Product shifted down by the fraction and capped at 2^60, then signed.
  function automatic logic signed [63:0] cap_term(logic [83:0] p, logic neg);
    logic [67:0]        s;
    logic signed [63:0] t;
    s = p[83:FRAC_BITS];
    t = (s > 68'(MAG_CAP)) ? $signed(64'(MAG_CAP)) : $signed({3'b0, s[60:0]});
    return neg ? -t : t;
  endfunction

endpackage

FILE: sv/pwsd_div.sv
// Shared radix-4 restoring divider for unsigned quotients.
`timescale 1ns / 1ps
module pwsd_div (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [pwsd_pkg::DIVN_W-1:0]    dividend_i,
  input  logic [pwsd_pkg::DIVD_W-1:0]    divisor_i,
  output logic                           done_o,
  output logic [pwsd_pkg::DIVN_W-1:0]    quotient_o
);

  localparam int STEPS = pwsd_pkg::DIVN_W / pwsd_pkg::DIV_RADIX;
  localparam int CNT_W = $clog2(STEPS + 1);

  logic [CNT_W-1:0]              cnt_q;
  logic                          busy_q, done_q;
  logic [pwsd_pkg::DIVD_W:0]     rem_q, rem_d;
  logic [pwsd_pkg::DIVN_W-1:0]   quo_q, quo_d;
  logic [pwsd_pkg::DIVD_W-1:0]   dvsr_q;

  always_comb begin
    rem_d = rem_q;
    quo_d = quo_q;
    for (int i = 0; i < pwsd_pkg::DIV_RADIX; i++) begin
      rem_d = {rem_d[pwsd_pkg::DIVD_W-1:0], quo_d[pwsd_pkg::DIVN_W-1]};
      quo_d = {quo_d[pwsd_pkg::DIVN_W-2:0], 1'b0};
      if (rem_d >= {1'b0, dvsr_q}) begin
        rem_d = rem_d - {1'b0, dvsr_q};
        quo_d[0] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else if (start_i) begin
      cnt_q  <= CNT_W'(STEPS);
      busy_q <= 1'b1;
      done_q <= 1'b0;
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == CNT_W'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= '0;
      quo_q  <= dividend_i;
      dvsr_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

FILE: sv/pid_with_sigmoid_deadzone_unit.sv
// Top level of the PID unit with a sigmoid-shaped adaptive deadband on the error.
`timescale 1ns / 1ps
// A control step makes three passes through the shared divider (width ratio, integral step,
// derivative) and otherwise steps through sequencer states around the shared 33 by 33
// multiplier. A clear item or a step of 1 us or less goes from the check state straight to
// the finish state. The input stays stalled until the sequencer is idle again, so a new item
// is not taken before the previous one is finished. A new item is taken even while the
// previous result still waits in the output register, and the sequencer holds its finished
// result until that register is free.
module pid_with_sigmoid_deadzone_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  pwsd_pkg::pwsd_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output pwsd_pkg::pwsd_out_t out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [2:0]          cfg_index_i,
  input  logic [31:0]         cfg_data_i
);

  localparam int FB = pwsd_pkg::FRAC_BITS;

  pwsd_pkg::state_e   state_q, state_d;
  pwsd_pkg::pwsd_in_t item_q;
  pwsd_pkg::pwsd_out_t res_q, out_q;
  logic               out_valid_q, load;

  logic signed [31:0] gp_q, gi_q, gd_q, cmin_q, cmax_q, slope_q;
  logic [30:0]        thr_q, center_q;

  logic [32:0]        ma, mb;
  logic [65:0]        prod_q;
  logic [63:0]        plo_q;
  logic signed [32:0] diff_q, cmd_q, ddiff_q;
  logic [pwsd_pkg::X_W-1:0]      ax_q;
  logic               neg_q;
  logic [pwsd_pkg::SIG_W-1:0]    lo_q, hi_q, s_q;
  logic [pwsd_pkg::SIG_FR_W-1:0] frac_q;
  logic signed [34:0] coef_q;
  logic signed [31:0] err_q, last_q;
  logic signed [23:0] integ_q;
  logic [pwsd_pkg::DIVN_W-1:0]   dmag_q;
  logic signed [63:0] acc_q;

  logic                        div_start, div_done;
  logic [pwsd_pkg::DIVN_W-1:0] div_dvnd, div_quo;
  logic [pwsd_pkg::DIVD_W-1:0] div_dvsr;

  logic [49:0]                   xs, lm;
  logic [pwsd_pkg::X_W-1:0]      ax;
  logic [pwsd_pkg::SIG_IDX_W-1:0] idx;
  logic [pwsd_pkg::SIG_W-1:0]    dlt, sv;
  logic [32:0]                   ct, delta;
  logic signed [34:0]            ns;
  logic [31:0]                   errmag;
  logic [83:0]                   full;

  pwsd_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvnd),
    .divisor_i  (div_dvsr),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  assign in_stall_o  = (state_q != pwsd_pkg::ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign load = (state_q == pwsd_pkg::ST_FIN) && (!out_valid_q || !out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pwsd_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    ma        = '0;
    mb        = '0;
    div_start = 1'b0;
    div_dvnd  = '0;
    div_dvsr  = '0;
    unique case (state_q)
      pwsd_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = pwsd_pkg::ST_CHECK;
      end
      pwsd_pkg::ST_CHECK: begin
        if (item_q.mode || item_q.step_time_us <= 20'd1) begin
          state_d = pwsd_pkg::ST_FIN;
        end else begin
          div_start = 1'b1;
          div_dvnd  = pwsd_pkg::DIVN_W'(item_q.target_width) << FB;
          div_dvsr  = (item_q.frame_size == '0) ? pwsd_pkg::DIVD_W'(1)
                                                 : pwsd_pkg::DIVD_W'(item_q.frame_size);
          state_d   = pwsd_pkg::ST_RATIO;
        end
      end
      pwsd_pkg::ST_RATIO: begin
        if (div_done) state_d = pwsd_pkg::ST_XMUL;
      end
      pwsd_pkg::ST_XMUL: begin
        ma = 33'(pwsd_pkg::mag64(64'(slope_q)));
        mb = 33'(pwsd_pkg::mag64(64'(diff_q)));
        state_d = pwsd_pkg::ST_XCAP;
      end
      pwsd_pkg::ST_XCAP: state_d = pwsd_pkg::ST_TAB;
      pwsd_pkg::ST_TAB:  state_d = pwsd_pkg::ST_INTERP_MUL;
      pwsd_pkg::ST_INTERP_MUL: begin
        ma = 33'(dlt);
        mb = 33'(frac_q);
        state_d = pwsd_pkg::ST_SIG;
      end
      pwsd_pkg::ST_SIG: state_d = pwsd_pkg::ST_CMUL;
      pwsd_pkg::ST_CMUL: begin
        ma = 33'(s_q);
        mb = 33'(pwsd_pkg::mag64(64'(cmd_q)));
        state_d = pwsd_pkg::ST_COEF;
      end
      pwsd_pkg::ST_COEF: state_d = pwsd_pkg::ST_LMUL;
      pwsd_pkg::ST_LMUL: begin
        ma = 33'(pwsd_pkg::mag64(64'(coef_q)));
        mb = 33'(thr_q);
        state_d = pwsd_pkg::ST_LIMIT;
      end
      pwsd_pkg::ST_LIMIT: state_d = pwsd_pkg::ST_DTMUL;
      pwsd_pkg::ST_DTMUL: begin
        ma = 33'(pwsd_pkg::mag64(64'(err_q)));
        mb = 33'(item_q.step_time_us);
        state_d = pwsd_pkg::ST_DTDIV;
      end
      pwsd_pkg::ST_DTDIV: begin
        div_start = 1'b1;
        div_dvnd  = prod_q[pwsd_pkg::DIVN_W-1:0];
        div_dvsr  = pwsd_pkg::US_PER_S;
        state_d   = pwsd_pkg::ST_DTWAIT;
      end
      pwsd_pkg::ST_DTWAIT: begin
        if (div_done) state_d = pwsd_pkg::ST_DRMUL;
      end
      pwsd_pkg::ST_DRMUL: begin
        ma = 33'(pwsd_pkg::mag64(64'(ddiff_q)));
        mb = 33'(pwsd_pkg::US_PER_S);
        state_d = pwsd_pkg::ST_DRDIV;
      end
      pwsd_pkg::ST_DRDIV: begin
        div_start = 1'b1;
        div_dvnd  = prod_q[pwsd_pkg::DIVN_W-1:0];
        div_dvsr  = item_q.step_time_us;
        state_d   = pwsd_pkg::ST_DRWAIT;
      end
      pwsd_pkg::ST_DRWAIT: begin
        if (div_done) state_d = pwsd_pkg::ST_PMUL;
      end
      pwsd_pkg::ST_PMUL: begin
        ma = 33'(pwsd_pkg::mag64(64'(gp_q)));
        mb = 33'(pwsd_pkg::mag64(64'(err_q)));
        state_d = pwsd_pkg::ST_PACC;
      end
      pwsd_pkg::ST_PACC: state_d = pwsd_pkg::ST_GIMUL;
      pwsd_pkg::ST_GIMUL: begin
        ma = 33'(pwsd_pkg::mag64(64'(gi_q)));
        mb = 33'(pwsd_pkg::mag64(64'(integ_q)));
        state_d = pwsd_pkg::ST_GIACC;
      end
      pwsd_pkg::ST_GIACC: state_d = pwsd_pkg::ST_GDMLO;
      pwsd_pkg::ST_GDMLO: begin
        ma = 33'(pwsd_pkg::mag64(64'(gd_q)));
        mb = 33'(dmag_q[31:0]);
        state_d = pwsd_pkg::ST_GDMHI;
      end
      pwsd_pkg::ST_GDMHI: begin
        ma = 33'(pwsd_pkg::mag64(64'(gd_q)));
        mb = 33'(dmag_q[pwsd_pkg::DIVN_W-1:32]);
        state_d = pwsd_pkg::ST_GDACC;
      end
      pwsd_pkg::ST_GDACC: state_d = pwsd_pkg::ST_SAT;
      pwsd_pkg::ST_SAT:   state_d = pwsd_pkg::ST_FIN;
      pwsd_pkg::ST_FIN: begin
        if (!out_valid_q || !out_stall_i) state_d = pwsd_pkg::ST_IDLE;
      end
      default: state_d = pwsd_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    xs     = prod_q[65:FB];
    ax     = (xs > 50'(pwsd_pkg::X_LIMIT)) ? pwsd_pkg::X_LIMIT : xs[pwsd_pkg::X_W-1:0];
    idx    = ax_q[pwsd_pkg::X_SHIFT-1:pwsd_pkg::SIG_FR_W];
    dlt    = (hi_q > lo_q) ? hi_q - lo_q : '0;
    sv     = lo_q + prod_q[pwsd_pkg::SIG_W+pwsd_pkg::SIG_FR_W-1:pwsd_pkg::SIG_FR_W];
    ct     = prod_q[FB+32:FB];
    lm     = prod_q[65:FB];
    errmag = 32'(pwsd_pkg::mag64(64'(item_q.error_in)));
    delta  = div_quo[32:0];
    ns     = 35'(integ_q) + (err_q[31] ? -$signed({2'b0, delta}) : $signed({2'b0, delta}));
    full   = ({18'b0, prod_q} << 32) + {20'b0, plo_q};
  end

  always_ff @(posedge clk_i) begin
    prod_q <= ma * mb;
    unique case (state_q)
      pwsd_pkg::ST_IDLE: begin
        if (in_valid_i) item_q <= in_data_i;
      end
      pwsd_pkg::ST_CHECK: begin
        res_q.drive_out     <= '0;
        res_q.step_rejected <= 1'b1;
      end
      pwsd_pkg::ST_RATIO: begin
        if (div_done) begin
          diff_q <= $signed({3'b0, div_quo[29:0]}) - $signed({2'b0, center_q});
        end
      end
      pwsd_pkg::ST_XCAP: begin
        ax_q  <= ax;
        neg_q <= (slope_q[31] != diff_q[32]) && (ax != '0);
      end
      pwsd_pkg::ST_TAB: begin
        if (ax_q >= pwsd_pkg::X_LIMIT) begin
          lo_q   <= pwsd_pkg::SIG_TAB[pwsd_pkg::SIG_DEPTH];
          hi_q   <= pwsd_pkg::SIG_TAB[pwsd_pkg::SIG_DEPTH];
          frac_q <= '0;
        end else begin
          lo_q   <= pwsd_pkg::SIG_TAB[idx];
          hi_q   <= pwsd_pkg::SIG_TAB[{1'b0, idx} + 1'b1];
          frac_q <= ax_q[pwsd_pkg::SIG_FR_W-1:0];
        end
      end
      pwsd_pkg::ST_SIG: begin
        s_q   <= neg_q ? pwsd_pkg::SIG_ONE - sv : sv;
        cmd_q <= 33'(cmax_q) - 33'(cmin_q);
      end
      pwsd_pkg::ST_COEF: begin
        coef_q <= 35'(cmin_q) + (cmd_q[32] ? -$signed({2'b0, ct}) : $signed({2'b0, ct}));
      end
      pwsd_pkg::ST_LIMIT: begin
        err_q <= (!coef_q[34] && ({18'b0, errmag} < lm)) ? '0 : item_q.error_in;
      end
      pwsd_pkg::ST_DTWAIT: begin
        if (div_done) ddiff_q <= 33'(err_q) - 33'(last_q);
      end
      pwsd_pkg::ST_DRWAIT: begin
        if (div_done) dmag_q <= div_quo;
      end
      pwsd_pkg::ST_PACC: begin
        acc_q <= pwsd_pkg::cap_term({18'b0, prod_q}, gp_q[31] != err_q[31]);
      end
      pwsd_pkg::ST_GIACC: begin
        acc_q <= acc_q + pwsd_pkg::cap_term({18'b0, prod_q}, gi_q[31] != integ_q[23]);
      end
      pwsd_pkg::ST_GDMHI: begin
        plo_q <= prod_q[63:0];
      end
      pwsd_pkg::ST_GDACC: begin
        acc_q <= acc_q + pwsd_pkg::cap_term(full, gd_q[31] != ddiff_q[32]);
      end
      pwsd_pkg::ST_SAT: begin
        res_q.step_rejected <= 1'b0;
        if (acc_q > pwsd_pkg::OUT_LIMIT) begin
          res_q.drive_out <= 23'(pwsd_pkg::OUT_LIMIT);
        end else if (acc_q < -pwsd_pkg::OUT_LIMIT) begin
          res_q.drive_out <= 23'(-pwsd_pkg::OUT_LIMIT);
        end else begin
          res_q.drive_out <= 23'(acc_q);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      integ_q <= '0;
      last_q  <= '0;
    end else if (state_q == pwsd_pkg::ST_CHECK && item_q.mode) begin
      integ_q <= '0;
      last_q  <= '0;
    end else if (state_q == pwsd_pkg::ST_DTWAIT && div_done) begin
      last_q <= err_q;
      if (ns > pwsd_pkg::INT_LIMIT) begin
        integ_q <= 24'(pwsd_pkg::INT_LIMIT);
      end else if (ns < -pwsd_pkg::INT_LIMIT) begin
        integ_q <= 24'(-pwsd_pkg::INT_LIMIT);
      end else begin
        integ_q <= 24'(ns);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gp_q     <= pwsd_pkg::GAIN_P_RST;
      gi_q     <= pwsd_pkg::GAIN_I_RST;
      gd_q     <= pwsd_pkg::GAIN_D_RST;
      thr_q    <= '0;
      cmin_q   <= '0;
      cmax_q   <= '0;
      slope_q  <= '0;
      center_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (pwsd_pkg::cfg_idx_e'(cfg_index_i))
        pwsd_pkg::CFG_GAIN_P:       gp_q     <= cfg_data_i;
        pwsd_pkg::CFG_GAIN_I:       gi_q     <= cfg_data_i;
        pwsd_pkg::CFG_GAIN_D:       gd_q     <= cfg_data_i;
        pwsd_pkg::CFG_DZ_THRESHOLD: thr_q    <= cfg_data_i[30:0];
        pwsd_pkg::CFG_COEF_MIN:     cmin_q   <= cfg_data_i;
        pwsd_pkg::CFG_COEF_MAX:     cmax_q   <= cfg_data_i;
        pwsd_pkg::CFG_SIG_SLOPE:    slope_q  <= cfg_data_i;
        pwsd_pkg::CFG_SIG_CENTER:   center_q <= cfg_data_i[30:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) out_q <= res_q;
  end

endmodule
